[rtl/cnsl_pkg.sv]
// Shared types, codes and BCD helpers for the console register block.
`timescale 1ns / 1ps

package cnsl_pkg;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_TICK  = 2'd2
  } cnsl_kind_t;

  typedef enum logic [2:0] {
    REG_INTR      = 3'd0,
    REG_TIME_UP   = 3'd1,
    REG_TIME_LOW  = 3'd2,
    REG_DATE_LOW  = 3'd3,
    REG_DATE_UP   = 3'd4,
    REG_TTY_DATA  = 3'd5,
    REG_TTY_CTRL  = 3'd6,
    REG_SWITCHES  = 3'd7
  } cnsl_reg_t;

  // Interrupt flag bit positions.
  localparam int unsigned FLAG_FCI = 0;
  localparam int unsigned FLAG_TCI = 1;
  localparam int unsigned FLAG_SCI = 3;

  // Teletype control bit that selects input mode.
  localparam int unsigned CTRL_INPUT_MODE = 5;

  localparam logic [7:0] HOOT_ON    = 8'd255;
  localparam logic [8:0] YEAR_BASE  = 9'd50;
  localparam logic [8:0] YEAR_SPAN  = 9'd100;

  typedef struct packed {
    logic [1:0]  kind;
    cnsl_reg_t   reg_index;
    logic [15:0] write_value;
    logic [4:0]  clock_hour;
    logic [5:0]  clock_minute;
    logic [5:0]  clock_second;
    logic [3:0]  clock_month;
    logic [4:0]  clock_day;
    logic [7:0]  clock_year;
  } cnsl_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        tty_valid;
    logic [7:0]  tty_char;
    logic        irq_pulse;
    logic [7:0]  hoot_level;
  } cnsl_result_t;

  // Two BCD digits of a value below 100; the quotient by ten comes from a
  // multiply by 205/2048, which is exact for every 7-bit input.
  function automatic logic [7:0] to_bcd(input logic [6:0] n);
    logic [14:0] prod;
    logic [3:0]  q;
    logic [6:0]  tens;
    logic [6:0]  rem;
    prod = 15'(n) * 15'd205;
    q    = prod[14:11];
    tens = {q, 3'b000} + {2'b00, q, 1'b0};
    rem  = n - tens;
    return {q, rem[3:0]};
  endfunction

  // (year - 50) mod 100 as a true modulo, written as (year + 50) mod 100.
  function automatic logic [6:0] year_mod(input logic [7:0] y);
    logic [8:0] s;
    s = {1'b0, y} + YEAR_BASE;
    if (s >= 9'(2 * YEAR_SPAN)) s = s - 9'(2 * YEAR_SPAN);
    if (s >= YEAR_SPAN) s = s - YEAR_SPAN;
    return s[6:0];
  endfunction

endpackage

[rtl/cnsl_ifs.sv]
// Valid/ready channel interfaces for the console input and result beats.
`timescale 1ns / 1ps

interface cnsl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  reg_index;
  logic [15:0] write_value;
  logic [4:0]  clock_hour;
  logic [5:0]  clock_minute;
  logic [5:0]  clock_second;
  logic [3:0]  clock_month;
  logic [4:0]  clock_day;
  logic [7:0]  clock_year;

  modport source (
    output valid, kind, reg_index, write_value, clock_hour, clock_minute,
           clock_second, clock_month, clock_day, clock_year,
    input  ready
  );
  modport sink (
    input  valid, kind, reg_index, write_value, clock_hour, clock_minute,
           clock_second, clock_month, clock_day, clock_year,
    output ready
  );
endinterface

interface cnsl_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        tty_valid;
  logic [7:0]  tty_char;
  logic        irq_pulse;
  logic [7:0]  hoot_level;

  modport source (
    output valid, read_data, tty_valid, tty_char, irq_pulse, hoot_level,
    input  ready
  );
  modport sink (
    input  valid, read_data, tty_valid, tty_char, irq_pulse, hoot_level,
    output ready
  );
endinterface

[rtl/cnsl_core.sv]
// Console register file and the single-pass decode of one beat.
`timescale 1ns / 1ps

module cnsl_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire_i,
  input  cnsl_pkg::cnsl_item_t  item_i,
  output cnsl_pkg::cnsl_result_t result_o
);

  logic [3:0]  flags_r,    flags_nxt;
  logic [7:0]  tty_data_r, tty_data_nxt;
  logic [7:0]  tty_ctrl_r, tty_ctrl_nxt;
  logic        pending_r,  pending_nxt;
  logic [15:0] switch_r,   switch_nxt;
  logic [15:0] time_low_r, time_low_nxt;
  logic [7:0]  hoot_r,     hoot_nxt;

  logic [7:0] bcd_hour, bcd_minute, bcd_second, bcd_month, bcd_day, bcd_year;

  assign bcd_hour   = cnsl_pkg::to_bcd({2'b00, item_i.clock_hour});
  assign bcd_minute = cnsl_pkg::to_bcd({1'b0, item_i.clock_minute});
  assign bcd_second = cnsl_pkg::to_bcd({1'b0, item_i.clock_second});
  assign bcd_month  = cnsl_pkg::to_bcd({3'b000, item_i.clock_month});
  assign bcd_day    = cnsl_pkg::to_bcd({2'b00, item_i.clock_day});
  assign bcd_year   = cnsl_pkg::to_bcd(cnsl_pkg::year_mod(item_i.clock_year));

  always_comb begin
    flags_nxt    = flags_r;
    tty_data_nxt = tty_data_r;
    tty_ctrl_nxt = tty_ctrl_r;
    pending_nxt  = pending_r;
    switch_nxt   = switch_r;
    time_low_nxt = time_low_r;
    hoot_nxt     = hoot_r;
    result_o     = '0;

    case (item_i.kind)
      cnsl_pkg::KIND_READ: begin
        unique case (item_i.reg_index)
          cnsl_pkg::REG_INTR:     result_o.read_data = {12'd0, flags_r};
          cnsl_pkg::REG_TIME_UP: begin
            result_o.read_data = {bcd_hour, bcd_minute};
            time_low_nxt       = {bcd_second, 8'd0};
          end
          cnsl_pkg::REG_TIME_LOW: result_o.read_data = time_low_r;
          cnsl_pkg::REG_DATE_LOW: result_o.read_data = {bcd_month, bcd_day};
          cnsl_pkg::REG_DATE_UP: begin
            // The year register and the hooter level share one location.
            result_o.read_data = {8'd0, bcd_year};
            hoot_nxt           = bcd_year;
          end
          cnsl_pkg::REG_TTY_DATA: result_o.read_data = {8'd0, tty_data_r};
          cnsl_pkg::REG_TTY_CTRL: result_o.read_data = {8'd0, tty_ctrl_r};
          cnsl_pkg::REG_SWITCHES: result_o.read_data = switch_r;
          default:                result_o.read_data = '0;
        endcase
      end
      cnsl_pkg::KIND_WRITE: begin
        unique case (item_i.reg_index)
          cnsl_pkg::REG_INTR: begin
            if (item_i.write_value[cnsl_pkg::FLAG_TCI]) begin
              flags_nxt[cnsl_pkg::FLAG_TCI] = 1'b0;
            end else if (item_i.write_value[cnsl_pkg::FLAG_FCI]) begin
              flags_nxt[cnsl_pkg::FLAG_FCI] = 1'b0;
              flags_nxt[cnsl_pkg::FLAG_SCI] = 1'b0;
            end
          end
          cnsl_pkg::REG_DATE_UP: begin
            hoot_nxt = item_i.write_value[0] ? cnsl_pkg::HOOT_ON : 8'd0;
          end
          cnsl_pkg::REG_TTY_DATA: begin
            tty_data_nxt = item_i.write_value[7:0];
            pending_nxt  = 1'b1;
          end
          cnsl_pkg::REG_TTY_CTRL: tty_ctrl_nxt = item_i.write_value[7:0];
          cnsl_pkg::REG_SWITCHES: switch_nxt   = item_i.write_value;
          default: begin
          end
        endcase
      end
      cnsl_pkg::KIND_TICK: begin
        if (pending_r) begin
          if (!tty_ctrl_r[cnsl_pkg::CTRL_INPUT_MODE]) begin
            result_o.tty_valid            = 1'b1;
            result_o.tty_char             = tty_data_r;
            result_o.irq_pulse            = 1'b1;
            flags_nxt[cnsl_pkg::FLAG_TCI] = 1'b1;
          end
          pending_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase

    result_o.hoot_level = hoot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r    <= '0;
      tty_data_r <= '0;
      tty_ctrl_r <= '0;
      pending_r  <= 1'b0;
      switch_r   <= '0;
      time_low_r <= '0;
      hoot_r     <= '0;
    end else if (fire_i) begin
      flags_r    <= flags_nxt;
      tty_data_r <= tty_data_nxt;
      tty_ctrl_r <= tty_ctrl_nxt;
      pending_r  <= pending_nxt;
      switch_r   <= switch_nxt;
      time_low_r <= time_low_nxt;
      hoot_r     <= hoot_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_send_sets_tci: assert property (@(posedge clk) disable iff (!rst_n)
    fire_i && result_o.irq_pulse |=> flags_r[cnsl_pkg::FLAG_TCI])
    else $error("transmit interrupt not set after a sent character");

  a_tick_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
    fire_i && item_i.kind == cnsl_pkg::KIND_TICK |=> !pending_r)
    else $error("teletype pending survived a tick");

  a_send_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    result_o.tty_valid |-> pending_r && !tty_ctrl_r[cnsl_pkg::CTRL_INPUT_MODE])
    else $error("character sent without a pending output character");
`endif

endmodule

[rtl/console_register_block.sv]
// Top level of the console register block: input stage, core and result register.
//
//   channel  | dir | handshake          | payload
//   in_ch    | in  | valid / ready      | kind, reg_index, write_value, clock_*
//   out_ch   | out | valid / ready      | read_data, tty_valid, tty_char,
//            |     |                    | irq_pulse, hoot_level
//
// One beat is accepted per cycle unless out_ch stalls; each beat yields one result
// beat, from the input register through the core decode into the result register.
// Reset (rst_n low, synchronous) clears all console state and both valid flags.
// A stalled result holds the result register and, once the input stage is also
// full, drops in_ch.ready; console registers update only when a beat leaves the input stage.
`timescale 1ns / 1ps

module console_register_block (
  input  logic        clk,
  input  logic        rst_n,
  cnsl_in_if.sink     in_ch,
  cnsl_out_if.source  out_ch
);

  logic                   s1_valid_r;
  cnsl_pkg::cnsl_item_t   s1_item_r;
  logic                   out_valid_r;
  cnsl_pkg::cnsl_result_t out_res_r;
  cnsl_pkg::cnsl_result_t core_res;
  cnsl_pkg::cnsl_item_t   in_item;

  logic out_free;
  logic s1_fire;
  logic in_fire;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign in_item.kind         = in_ch.kind;
  assign in_item.reg_index    = cnsl_pkg::cnsl_reg_t'(in_ch.reg_index);
  assign in_item.write_value  = in_ch.write_value;
  assign in_item.clock_hour   = in_ch.clock_hour;
  assign in_item.clock_minute = in_ch.clock_minute;
  assign in_item.clock_second = in_ch.clock_second;
  assign in_item.clock_month  = in_ch.clock_month;
  assign in_item.clock_day    = in_ch.clock_day;
  assign in_item.clock_year   = in_ch.clock_year;

  cnsl_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire_i   (s1_fire),
    .item_i   (s1_item_r),
    .result_o (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) s1_valid_r <= in_ch.valid;
      if (out_free) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) s1_item_r <= in_item;
    if (s1_fire) out_res_r <= core_res;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_data  = out_res_r.read_data;
  assign out_ch.tty_valid  = out_res_r.tty_valid;
  assign out_ch.tty_char   = out_res_r.tty_char;
  assign out_ch.irq_pulse  = out_res_r.irq_pulse;
  assign out_ch.hoot_level = out_res_r.hoot_level;

`ifndef ASSERT_OFF
  a_tty_beat_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.tty_valid |-> out_ch.irq_pulse && out_ch.read_data == 16'd0)
    else $error("teletype beat carries read data or lacks its interrupt");

  a_idle_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.tty_valid |-> out_ch.tty_char == 8'd0)
    else $error("character present on a beat without a teletype send");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r && $stable(s1_item_r))
    else $error("input stage lost or changed a beat while stalled");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted while both stages are full and stalled");
`endif

endmodule
